FILE: sv/frbw_pkg.sv
// ----------------------------------------------------------------------------
// Framed ring buffer writer package
// Shared types and constants for the record planner, the result sequencer
// and the top level of the framed ring buffer writer.
// ----------------------------------------------------------------------------
package frbw_pkg;

  // Ring byte indices and the largest number of results one transaction causes.
  localparam int unsigned IDX_W   = 15;
  localparam int unsigned MAX_RES = 7;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned SEL_W   = 3;
  // Quotient of a read index by the ring size (ring size is at least 256).
  localparam int unsigned QUOT_W  = 7;

  // Operation codes.
  localparam logic [2:0] OP_SHORT      = 3'd0;
  localparam logic [2:0] OP_LONG_START = 3'd1;
  localparam logic [2:0] OP_LONG_BYTE  = 3'd2;
  localparam logic [2:0] OP_READ_IDX   = 3'd3;
  localparam logic [2:0] OP_RING_RESET = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NO_LONG  = 2'd2;

  // Write sizes.
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // Record markers and layout.
  localparam logic [31:0] END_MARK   = 32'd0;
  localparam logic [31:0] WRAP_MARK  = 32'd1;
  localparam logic [31:0] SHORT_MARK = 32'd2;
  localparam logic [16:0] HEADER_BYTES = 17'd8;
  localparam logic [16:0] SHORT_BYTES  = 17'd4;
  localparam logic [16:0] RESERVE      = 17'd2;
  localparam logic [IDX_W-1:0] OFS_INST = 15'd2;
  localparam logic [IDX_W-1:0] OFS_TS   = 15'd4;
  localparam logic [IDX_W-1:0] OFS_DATA = 15'd8;

  // One accepted input transaction, with the precomputed read index quotient.
  typedef struct packed {
    logic [2:0]        op;
    logic [15:0]       inst;
    logic [31:0]       ts;
    logic [31:0]       msg;
    logic [IDX_W-1:0]  len;
    logic [7:0]        data_byte;
    logic [IDX_W-1:0]  rix;
    logic [QUOT_W-1:0] rix_quot;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [31:0]      data;
    logic [1:0]       size;
    logic [1:0]       status;
  } res_t;

  // All results of one input transaction, in order, with their count.
  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } plan_t;

endpackage

FILE: sv/frbw_planner.sv
// ----------------------------------------------------------------------------
// Record planner
// Holds the ring indices and long message state, checks space for a new
// record and lays out the list of ring writes for one input transaction.
// ----------------------------------------------------------------------------
module frbw_planner #(
  parameter int unsigned RING_SIZE = 32768
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  frbw_pkg::item_t item_i,
  input  logic           commit_i,
  output frbw_pkg::plan_t plan_o
);
  import frbw_pkg::*;

  localparam logic [16:0] RING17 = 17'(RING_SIZE);

  logic [IDX_W-1:0] wi_q, wi_d;
  logic [IDX_W-1:0] ci_q, ci_d;
  logic [IDX_W-1:0] rs_q, rs_d;
  logic [15:0]      rl_q, rl_d;
  logic [IDX_W-1:0] br_q, br_d;
  logic [IDX_W-1:0] bp_q, bp_d;
  logic             active_q, active_d;

  logic [16:0] used, free_bytes, block, need, end_sum;
  logic        space_ovf, wrap, wrap_ovf, len_big;
  logic [IDX_W-1:0] rec_start, end_idx;
  logic [23:0] quot_prod;
  logic [16:0] rem_raw, rem_fix;
  logic [16:0] long_end;
  logic [IDX_W-1:0] br_dec;
  plan_t plan;
  logic [CNT_W-1:0] n;

  function automatic res_t wr(input logic [IDX_W-1:0] addr, input logic [31:0] data,
                              input logic [1:0] size);
    res_t r;
    r.we     = 1'b1;
    r.addr   = addr;
    r.data   = data;
    r.size   = size;
    r.status = ST_OK;
    return r;
  endfunction

  function automatic res_t noop(input logic [1:0] status);
    res_t r;
    r        = '0;
    r.status = status;
    return r;
  endfunction

  // Space check and wrap decision shared by short and long records.
  always_comb begin
    if (wi_q >= ci_q) begin
      used = {2'b00, wi_q} - {2'b00, ci_q};
    end else begin
      used = {2'b00, wi_q} + RING17 - {2'b00, ci_q};
    end
    free_bytes = RING17 - used;
    block      = (item_i.op == OP_SHORT) ? (HEADER_BYTES + SHORT_BYTES)
                                         : (HEADER_BYTES + {2'b00, item_i.len});
    need       = block + RESERVE;
    space_ovf  = free_bytes <= need;
    end_sum    = {2'b00, wi_q} + block;
    wrap       = RING17 <= (end_sum + RESERVE);
    wrap_ovf   = wrap && ({2'b00, ci_q} <= need);
    rec_start  = wrap ? '0 : wi_q;
    end_idx    = wrap ? block[IDX_W-1:0] : end_sum[IDX_W-1:0];
    len_big    = {2'b00, item_i.len} >= RING17;
  end

  // Read index reduced modulo the ring size; the quotient is low by at most one.
  always_comb begin
    quot_prod = 24'(item_i.rix_quot) * 24'(RING17);
    rem_raw   = 17'({9'b0, item_i.rix} - quot_prod);
    rem_fix   = (rem_raw >= RING17) ? (rem_raw - RING17) : rem_raw;
  end

  assign long_end = {2'b00, rs_q} + {1'b0, rl_q};
  assign br_dec   = br_q - 15'd1;

  // Result list and next state for the transaction in the input register.
  always_comb begin
    plan     = '0;
    n        = '0;
    wi_d     = wi_q;
    ci_d     = ci_q;
    rs_d     = rs_q;
    rl_d     = rl_q;
    br_d     = br_q;
    bp_d     = bp_q;
    active_d = active_q;
    unique case (item_i.op)
      OP_SHORT: begin
        active_d = 1'b0;
        if (space_ovf || wrap_ovf) begin
          plan.ent[0] = noop(ST_OVERFLOW);
          n = 3'd1;
        end else begin
          if (wrap) begin
            plan.ent[n] = wr('0, END_MARK, SZ_HALF);
            n = n + 3'd1;
            plan.ent[n] = wr(wi_q, WRAP_MARK, SZ_HALF);
            n = n + 3'd1;
          end
          plan.ent[n] = wr(rec_start + OFS_INST, {16'b0, item_i.inst}, SZ_HALF);
          n = n + 3'd1;
          plan.ent[n] = wr(rec_start + OFS_TS, item_i.ts, SZ_WORD);
          n = n + 3'd1;
          plan.ent[n] = wr(end_idx, END_MARK, SZ_HALF);
          n = n + 3'd1;
          plan.ent[n] = wr(rec_start + OFS_DATA, item_i.msg, SZ_WORD);
          n = n + 3'd1;
          plan.ent[n] = wr(rec_start, SHORT_MARK, SZ_HALF);
          n = n + 3'd1;
          wi_d = end_idx;
        end
      end
      OP_LONG_START: begin
        active_d = 1'b0;
        if (item_i.len == '0) begin
          plan.ent[0] = noop(ST_OK);
          n = 3'd1;
        end else if (len_big || space_ovf || wrap_ovf) begin
          plan.ent[0] = noop(ST_OVERFLOW);
          n = 3'd1;
        end else begin
          if (wrap) begin
            plan.ent[n] = wr('0, END_MARK, SZ_HALF);
            n = n + 3'd1;
            plan.ent[n] = wr(wi_q, WRAP_MARK, SZ_HALF);
            n = n + 3'd1;
          end
          plan.ent[n] = wr(rec_start + OFS_INST, {16'b0, item_i.inst}, SZ_HALF);
          n = n + 3'd1;
          plan.ent[n] = wr(rec_start + OFS_TS, item_i.ts, SZ_WORD);
          n = n + 3'd1;
          plan.ent[n] = wr(end_idx, END_MARK, SZ_HALF);
          n = n + 3'd1;
          // The header word waits for the final payload byte.
          wi_d     = rec_start;
          rs_d     = rec_start;
          rl_d     = block[15:0];
          br_d     = item_i.len;
          bp_d     = rec_start + OFS_DATA;
          active_d = 1'b1;
        end
      end
      OP_LONG_BYTE: begin
        if (!active_q) begin
          plan.ent[0] = noop(ST_NO_LONG);
          n = 3'd1;
        end else begin
          plan.ent[0] = wr(bp_q, {24'b0, item_i.data_byte}, SZ_BYTE);
          n    = 3'd1;
          bp_d = bp_q + 15'd1;
          br_d = br_dec;
          if (br_dec == '0) begin
            plan.ent[1] = wr(rs_q, {16'b0, rl_q}, SZ_HALF);
            n        = 3'd2;
            wi_d     = long_end[IDX_W-1:0];
            active_d = 1'b0;
          end
        end
      end
      OP_READ_IDX: begin
        ci_d = rem_fix[IDX_W-1:0];
        plan.ent[0] = noop(ST_OK);
        n = 3'd1;
      end
      OP_RING_RESET: begin
        wi_d     = '0;
        ci_d     = '0;
        rs_d     = '0;
        rl_d     = '0;
        br_d     = '0;
        bp_d     = '0;
        active_d = 1'b0;
        plan.ent[0] = wr('0, END_MARK, SZ_HALF);
        n = 3'd1;
      end
      default: begin
        plan.ent[0] = noop(ST_OK);
        n = 3'd1;
      end
    endcase
    plan.cnt = n;
  end

  assign plan_o = plan;

  // State advances when the plan is handed to the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q     <= '0;
      ci_q     <= '0;
      rs_q     <= '0;
      rl_q     <= '0;
      br_q     <= '0;
      bp_q     <= '0;
      active_q <= 1'b0;
    end else if (commit_i) begin
      wi_q     <= wi_d;
      ci_q     <= ci_d;
      rs_q     <= rs_d;
      rl_q     <= rl_d;
      br_q     <= br_d;
      bp_q     <= bp_d;
      active_q <= active_d;
    end
  end

`ifndef ASSERT_OFF
  // A pending long message always has bytes still to come.
  a_active_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (br_q != '0))
    else $error("long message pending with no bytes remaining");
`endif

endmodule

FILE: sv/frbw_sequencer.sv
// ----------------------------------------------------------------------------
// Result sequencer
// Holds the result list of one transaction and presents its entries one per
// cycle on the result ports, marking the final one.
// ----------------------------------------------------------------------------
module frbw_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  frbw_pkg::plan_t plan_i,
  output logic            free_o,
  output logic            valid_o,
  output logic            last_o,
  output frbw_pkg::res_t  res_o
);
  import frbw_pkg::*;

  res_t [MAX_RES-1:0] list_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SEL_W-1:0]   idx_q;
  logic               valid_q;
  logic               seq_last;
  res_t               cur;

  // Current entry and end of list.
  assign cur      = list_q[idx_q];
  assign seq_last = valid_q && (idx_q == (cnt_q - 3'd1));
  assign free_o   = !valid_q || seq_last;
  assign valid_o  = valid_q;
  assign last_o   = seq_last;
  assign res_o    = valid_q ? cur : '0;

  // List storage, loaded whole when a new plan arrives.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      list_q <= plan_i.ent;
    end
  end

  // Position within the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= plan_i.cnt;
      idx_q   <= '0;
    end else if (seq_last) begin
      valid_q <= 1'b0;
    end else if (valid_q) begin
      idx_q <= idx_q + 3'd1;
    end
  end

`ifndef ASSERT_OFF
  // The results of one transaction come in consecutive cycles.
  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("result list interrupted before its final entry");

  // A live list is never empty and the position stays inside it.
  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ((cnt_q != '0) && (idx_q < cnt_q)))
    else $error("result index outside the list");

  // A new list is only loaded when the previous one is done.
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result list overwritten while still in progress");
`endif

endmodule

FILE: sv/framed_ring_buffer_writer.sv
// ----------------------------------------------------------------------------
// Framed ring buffer writer
// A start transaction waits in the input register until the sequencer is free;
// a new one is accepted while the previous one's results are still presented.
// The sequencer gives one result per cycle, up to seven per transaction (the ring
// writes of a short record). Reset clears both ring indices and any pending long message.
// Producer side of a byte ring of framed records; every ring write is a result.
// ----------------------------------------------------------------------------
module framed_ring_buffer_writer #(
  parameter int unsigned RING_SIZE = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic [15:0] instance_id_i,
  input  logic [31:0] timestamp_i,
  input  logic [31:0] message_word_i,
  input  logic [14:0] long_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic [14:0] read_index_i,
  output logic        result_valid_o,
  output logic        write_enable_o,
  output logic [14:0] write_address_o,
  output logic [31:0] write_data_o,
  output logic [1:0]  write_size_o,
  output logic [1:0]  status_o,
  output logic        last_o
);
  import frbw_pkg::*;

  // Reciprocal of the ring size for the read index reduction.
  localparam int unsigned RECIP_SH = 30;
  localparam logic [22:0] RECIP    = 23'((64'd1 << RECIP_SH) / RING_SIZE);

  item_t item_q, item_d;
  logic  in_valid_q;
  logic  accept, load, seq_free;
  logic [37:0] quot_full;
  plan_t plan;
  res_t  res;

  // Input transaction handshake.
  assign busy   = in_valid_q && !seq_free;
  assign accept = start && !busy;
  assign load   = in_valid_q && seq_free;

  // Input register, with the read index quotient computed on the way in.
  always_comb begin
    quot_full          = 38'(read_index_i) * 38'(RECIP);
    item_d.op          = operation_i;
    item_d.inst        = instance_id_i;
    item_d.ts          = timestamp_i;
    item_d.msg         = message_word_i;
    item_d.len         = long_length_i;
    item_d.data_byte   = data_byte_i;
    item_d.rix         = read_index_i;
    item_d.rix_quot    = quot_full[RECIP_SH +: QUOT_W];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  frbw_planner #(
    .RING_SIZE(RING_SIZE)
  ) u_planner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .commit_i(load),
    .plan_o  (plan)
  );

  frbw_sequencer u_sequencer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .plan_i (plan),
    .free_o (seq_free),
    .valid_o(result_valid_o),
    .last_o (last_o),
    .res_o  (res)
  );

  // Result ports.
  assign write_enable_o  = res.we;
  assign write_address_o = res.addr;
  assign write_data_o    = res.data;
  assign write_size_o    = res.size;
  assign status_o        = res.status;

`ifndef ASSERT_OFF
  // An accepted transaction is held until the planner takes it.
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> in_valid_q)
    else $error("accepted transaction lost before planning");
`endif

endmodule
